@@ sv/vtd_pkg.sv @@
// ----------------------------------------------------------------------------
// vtd_pkg
// Shared types and constants of the vertex twist deformer: phase scaling,
// CORDIC gain and arctangent table, and the beat that rides the cell chain.
// ----------------------------------------------------------------------------
package vtd_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int ATAN_ENTRIES  = 24;

   // round(2^22 / (2*pi)): Q.26 radians to 2^-32 turn after a 16-bit shift
   localparam logic signed [20:0] PHASE_SCALE = 21'sd667544;
   localparam logic signed [52:0] PHASE_ROUND = 53'sd32768;
   localparam logic        [31:0] QUAD_OFFSET = 32'h2000_0000;

   // inverse CORDIC gain, Q2.30
   localparam logic signed [31:0] CORDIC_K    = 32'sh26DD3B6A;
   localparam logic signed [48:0] ROT_ROUND   = 49'sd536870912;
   localparam int                 ROT_SHIFT   = 30;

   typedef logic signed [15:0] coord_type;
   typedef logic signed [31:0] q30_type;

   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } quad_type;

   typedef struct packed {
      q30_type   x;
      q30_type   y;
      q30_type   z;
      quad_type  quad;
      coord_type px;
      coord_type py;
      coord_type pz;
      coord_type nx;
      coord_type ny;
      coord_type nz;
   } beat_type;

   // arctangent of 2^-i in 2^-32 turn units
   localparam q30_type ATAN_TURNS [ATAN_ENTRIES] = '{
      32'sh20000000, 32'sh12E4051D, 32'sh09FB385B, 32'sh051111D4,
      32'sh028B0D43, 32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55,
      32'sh0028BE53, 32'sh00145F2E, 32'sh000A2F98, 32'sh000517CC,
      32'sh00028BE6, 32'sh000145F3, 32'sh0000A2F9, 32'sh0000517C,
      32'sh000028BE, 32'sh0000145F, 32'sh00000A2F, 32'sh00000517,
      32'sh0000028B, 32'sh00000145, 32'sh000000A2, 32'sh00000051
   };

endpackage

@@ sv/vtd_front.sv @@
// ----------------------------------------------------------------------------
// vtd_front
// Angle front end: z times rate, scale to a 32-bit phase, fold by quadrant
// and load the CORDIC start vector. Three registered stages.
// ----------------------------------------------------------------------------
module vtd_front (
   input  logic                clock,
   input  logic                reset,
   input  vtd_pkg::coord_type  rate,
   input  logic                in_valid,
   output logic                in_stall,
   input  vtd_pkg::coord_type  in_pos_x,
   input  vtd_pkg::coord_type  in_pos_y,
   input  vtd_pkg::coord_type  in_pos_z,
   input  vtd_pkg::coord_type  in_norm_x,
   input  vtd_pkg::coord_type  in_norm_y,
   input  vtd_pkg::coord_type  in_norm_z,
   output logic                out_valid,
   output vtd_pkg::beat_type   out_beat,
   input  logic                out_stall
);

   logic                v1_ff, v2_ff, v3_ff;
   logic                en1, en2, en3;
   vtd_pkg::beat_type   b1_ff, b1_in, b2_ff, b3_ff, b3_in;
   logic signed [31:0]  prod_ff, prod_in;
   logic        [31:0]  phase_ff, phase_in;
   logic signed [52:0]  scaled_w;
   logic        [31:0]  offset_w;
   logic        [31:0]  resid_w;
   logic        [1:0]   quad_w;

   assign en3      = !v3_ff || !out_stall;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_stall = !en1;

   always_comb begin
      b1_in      = '0;
      b1_in.quad = vtd_pkg::QUAD_0;
      b1_in.px   = in_pos_x;
      b1_in.py   = in_pos_y;
      b1_in.pz   = in_pos_z;
      b1_in.nx   = in_norm_x;
      b1_in.ny   = in_norm_y;
      b1_in.nz   = in_norm_z;
   end

   assign prod_in  = 32'(in_pos_z) * 32'(rate);
   assign scaled_w = 53'(prod_ff) * 53'(vtd_pkg::PHASE_SCALE) + vtd_pkg::PHASE_ROUND;
   assign phase_in = scaled_w[47:16];

   assign offset_w = phase_ff + vtd_pkg::QUAD_OFFSET;
   assign quad_w   = offset_w[31:30];
   assign resid_w  = phase_ff - {quad_w, 30'd0};

   always_comb begin
      b3_in      = b2_ff;
      b3_in.x    = vtd_pkg::CORDIC_K;
      b3_in.y    = '0;
      b3_in.z    = $signed(resid_w);
      b3_in.quad = vtd_pkg::quad_type'(quad_w);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1 && in_valid) begin
         b1_ff   <= b1_in;
         prod_ff <= prod_in;
      end
      if (en2 && v1_ff) begin
         b2_ff    <= b1_ff;
         phase_ff <= phase_in;
      end
      if (en3 && v2_ff) begin
         b3_ff <= b3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_beat  = b3_ff;

endmodule

@@ sv/vtd_cell.sv @@
// ----------------------------------------------------------------------------
// vtd_cell
// One CORDIC rotation cell: shift-add micro-rotation by atan(2^-Index),
// registered, with local hold when the next cell stalls.
// ----------------------------------------------------------------------------
module vtd_cell #(
   parameter int Index = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_stall,
   input  vtd_pkg::beat_type  in_beat,
   output logic               out_valid,
   output vtd_pkg::beat_type  out_beat,
   input  logic               out_stall
);

   logic               valid_ff;
   vtd_pkg::beat_type  beat_ff, beat_in;
   vtd_pkg::q30_type   dx, dy;
   logic               en;

   assign en       = !valid_ff || !out_stall;
   assign in_stall = !en;

   assign dx = $signed(in_beat.y) >>> Index;
   assign dy = $signed(in_beat.x) >>> Index;

   always_comb begin
      beat_in = in_beat;
      if (!in_beat.z[31]) begin
         beat_in.x = in_beat.x - dx;
         beat_in.y = in_beat.y + dy;
         beat_in.z = in_beat.z - vtd_pkg::ATAN_TURNS[Index];
      end else begin
         beat_in.x = in_beat.x + dx;
         beat_in.y = in_beat.y - dy;
         beat_in.z = in_beat.z + vtd_pkg::ATAN_TURNS[Index];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en && in_valid) begin
         beat_ff <= beat_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

endmodule

@@ sv/vtd_back.sv @@
// ----------------------------------------------------------------------------
// vtd_back
// Rotation back end: quadrant unfold to cos/sin, four products, then round,
// shift and saturate into the output register. Two registered stages.
// ----------------------------------------------------------------------------
module vtd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_stall,
   input  vtd_pkg::beat_type   in_beat,
   output logic                out_valid,
   input  logic                out_stall,
   output vtd_pkg::coord_type  out_x,
   output vtd_pkg::coord_type  out_y,
   output vtd_pkg::coord_type  out_z,
   output vtd_pkg::coord_type  out_norm_x,
   output vtd_pkg::coord_type  out_norm_y,
   output vtd_pkg::coord_type  out_norm_z
);

   logic                v1_ff, v2_ff;
   logic                en1, en2;
   vtd_pkg::beat_type   b1_ff;
   vtd_pkg::q30_type    cos_w, sin_w;
   logic signed [47:0]  pxc_ff, pxc_in, pys_ff, pys_in, pyc_ff, pyc_in, pxs_ff, pxs_in;
   logic signed [48:0]  rx_w, ry_w;
   logic signed [48:0]  rx_sh, ry_sh;
   vtd_pkg::coord_type  x_ff, x_in, y_ff, y_in;
   vtd_pkg::coord_type  z_ff, nx_ff, ny_ff, nz_ff;

   function automatic vtd_pkg::coord_type sat16(input logic signed [48:0] v);
      vtd_pkg::coord_type r;
      if (v > 49'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -49'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   assign en2      = !v2_ff || !out_stall;
   assign en1      = !v1_ff || en2;
   assign in_stall = !en1;

   always_comb begin
      case (in_beat.quad)
         vtd_pkg::QUAD_0: begin
            cos_w = in_beat.x;
            sin_w = in_beat.y;
         end
         vtd_pkg::QUAD_1: begin
            cos_w = -in_beat.y;
            sin_w = in_beat.x;
         end
         vtd_pkg::QUAD_2: begin
            cos_w = -in_beat.x;
            sin_w = -in_beat.y;
         end
         default: begin
            cos_w = in_beat.y;
            sin_w = -in_beat.x;
         end
      endcase
   end

   assign pxc_in = 48'(in_beat.px) * 48'(cos_w);
   assign pys_in = 48'(in_beat.py) * 48'(sin_w);
   assign pyc_in = 48'(in_beat.py) * 48'(cos_w);
   assign pxs_in = 48'(in_beat.px) * 48'(sin_w);

   assign rx_w  = 49'(pxc_ff) + 49'(pys_ff) + vtd_pkg::ROT_ROUND;
   assign ry_w  = 49'(pyc_ff) - 49'(pxs_ff) + vtd_pkg::ROT_ROUND;
   assign rx_sh = rx_w >>> vtd_pkg::ROT_SHIFT;
   assign ry_sh = ry_w >>> vtd_pkg::ROT_SHIFT;
   assign x_in  = sat16(rx_sh);
   assign y_in  = sat16(ry_sh);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1 && in_valid) begin
         b1_ff  <= in_beat;
         pxc_ff <= pxc_in;
         pys_ff <= pys_in;
         pyc_ff <= pyc_in;
         pxs_ff <= pxs_in;
      end
      if (en2 && v1_ff) begin
         x_ff  <= x_in;
         y_ff  <= y_in;
         z_ff  <= b1_ff.pz;
         nx_ff <= b1_ff.nx;
         ny_ff <= b1_ff.ny;
         nz_ff <= b1_ff.nz;
      end
   end

   assign out_valid  = v2_ff;
   assign out_x      = x_ff;
   assign out_y      = y_ff;
   assign out_z      = z_ff;
   assign out_norm_x = nx_ff;
   assign out_norm_y = ny_ff;
   assign out_norm_z = nz_ff;

endmodule

@@ sv/vertex_twist_deform_unit.sv @@
// ----------------------------------------------------------------------------
// vertex_twist_deform_unit
// Twist deformer about z: rotates x/y by pos_z * twist_rate through a
// quadrant-folded, gain-compensated CORDIC cell chain; z and normal pass.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   pos_x/y/z, norm_x/y/z
//   rsp      out        rsp_valid/rsp_stall   out_x/y/z, out_norm_x/y/z
//   csr      in         csr_wr_en             csr_wr_data (twist_rate)
//
// One vertex per cycle while rsp is not stalled; the pipeline is 3 angle stages,
// one per CORDIC cell and 2 rotate stages, so its depth is set by the cell chain.
// reset is synchronous and empties every stage; twist_rate resets to 0.
// Every stage holds on its own stall, so bubbles close up and req is taken
// while a result waits on rsp; req_stall rises only once all stages are full.
// ----------------------------------------------------------------------------
module vertex_twist_deform_unit #(
   parameter int CordicStages = vtd_pkg::CORDIC_STAGES
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  vtd_pkg::coord_type  csr_wr_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  vtd_pkg::coord_type  req_pos_x,
   input  vtd_pkg::coord_type  req_pos_y,
   input  vtd_pkg::coord_type  req_pos_z,
   input  vtd_pkg::coord_type  req_norm_x,
   input  vtd_pkg::coord_type  req_norm_y,
   input  vtd_pkg::coord_type  req_norm_z,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output vtd_pkg::coord_type  rsp_out_x,
   output vtd_pkg::coord_type  rsp_out_y,
   output vtd_pkg::coord_type  rsp_out_z,
   output vtd_pkg::coord_type  rsp_out_norm_x,
   output vtd_pkg::coord_type  rsp_out_norm_y,
   output vtd_pkg::coord_type  rsp_out_norm_z
);

   vtd_pkg::coord_type  rate_ff;
   logic                chain_valid [CordicStages+1];
   logic                chain_stall [CordicStages+1];
   vtd_pkg::beat_type   chain_beat  [CordicStages+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= '0;
      end else if (csr_wr_en) begin
         rate_ff <= csr_wr_data;
      end
   end

   vtd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .rate      (rate_ff),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_pos_x  (req_pos_x),
      .in_pos_y  (req_pos_y),
      .in_pos_z  (req_pos_z),
      .in_norm_x (req_norm_x),
      .in_norm_y (req_norm_y),
      .in_norm_z (req_norm_z),
      .out_valid (chain_valid[0]),
      .out_beat  (chain_beat[0]),
      .out_stall (chain_stall[0])
   );

   for (genvar i = 0; i < CordicStages; i++) begin : g_cell
      vtd_cell #(.Index(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_stall  (chain_stall[i]),
         .in_beat   (chain_beat[i]),
         .out_valid (chain_valid[i+1]),
         .out_beat  (chain_beat[i+1]),
         .out_stall (chain_stall[i+1])
      );
   end

   vtd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (chain_valid[CordicStages]),
      .in_stall   (chain_stall[CordicStages]),
      .in_beat    (chain_beat[CordicStages]),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_x      (rsp_out_x),
      .out_y      (rsp_out_y),
      .out_z      (rsp_out_z),
      .out_norm_x (rsp_out_norm_x),
      .out_norm_y (rsp_out_norm_y),
      .out_norm_z (rsp_out_norm_z)
   );

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall && chain_valid[0] && chain_valid[CordicStages]))
      else $error("req stalled with room in the pipeline");

   a_chain_end_holds: assert property (@(posedge clock) disable iff (reset)
      (chain_valid[CordicStages] && chain_stall[CordicStages]) |=>
         (chain_valid[CordicStages] && $stable(chain_beat[CordicStages])))
      else $error("last cell dropped or changed a stalled beat");

   a_chain_head_holds: assert property (@(posedge clock) disable iff (reset)
      (chain_valid[0] && chain_stall[0]) |=>
         (chain_valid[0] && $stable(chain_beat[0])))
      else $error("front end dropped or changed a stalled beat");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid && !chain_valid[0]))
      else $error("pipeline not empty after reset");

endmodule

@@ verif/vertex_twist_deform_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vertex_twist_deform_checker
// Watches the csr, req and rsp ports of the twist deformer. It keeps its own
// copy of twist_rate and predicts every accepted vertex through a
// bit-accurate phase, quadrant and CORDIC model. Each rsp beat is checked in
// order against the oldest prediction. The checker reports its mismatch
// count and the number of predictions still waiting.
// ----------------------------------------------------------------------------
module vertex_twist_deform_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  vtd_pkg::coord_type  csr_wr_data,
   input  logic                req_valid,
   input  logic                req_stall,
   input  vtd_pkg::coord_type  req_pos_x,
   input  vtd_pkg::coord_type  req_pos_y,
   input  vtd_pkg::coord_type  req_pos_z,
   input  vtd_pkg::coord_type  req_norm_x,
   input  vtd_pkg::coord_type  req_norm_y,
   input  vtd_pkg::coord_type  req_norm_z,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  vtd_pkg::coord_type  rsp_out_x,
   input  vtd_pkg::coord_type  rsp_out_y,
   input  vtd_pkg::coord_type  rsp_out_z,
   input  vtd_pkg::coord_type  rsp_out_norm_x,
   input  vtd_pkg::coord_type  rsp_out_norm_y,
   input  vtd_pkg::coord_type  rsp_out_norm_z,
   output int                  mismatch_count,
   output int                  pending_count
);
   import vtd_pkg::*;

   typedef struct {
      coord_type x;
      coord_type y;
      coord_type z;
      coord_type nx;
      coord_type ny;
      coord_type nz;
   } deformed_vertex_type;

   deformed_vertex_type twisted_vertices[$];
   coord_type           rate_shadow;
   int                  bad_beats;

   function automatic coord_type clamp16(longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return coord_type'(v);
   endfunction

   function automatic deformed_vertex_type twist_vertex(
      coord_type px, coord_type py, coord_type pz,
      coord_type nx, coord_type ny, coord_type nz, coord_type rate);
      longint              angle_prod, resid, cx, sy, dx, dy, c, s;
      logic [63:0]         scaled;
      logic [31:0]         phase, quad_sum, residual;
      quad_type            quad;
      deformed_vertex_type v;
      angle_prod = longint'(pz) * longint'(rate);
      scaled     = angle_prod * longint'(PHASE_SCALE) + 64'd32768;
      phase      = scaled[47:16];
      quad_sum   = phase + QUAD_OFFSET;
      quad       = quad_type'(quad_sum[31:30]);
      residual   = phase - {quad_sum[31:30], 30'd0};
      resid      = longint'(signed'(residual));
      cx = longint'(CORDIC_K);
      sy = 0;
      for (int i = 0; i < CORDIC_STAGES && i < ATAN_ENTRIES; i++) begin
         dx = sy >>> i;
         dy = cx >>> i;
         if (resid >= 0) begin
            cx    = cx - dx;
            sy    = sy + dy;
            resid = resid - longint'(ATAN_TURNS[i]);
         end else begin
            cx    = cx + dx;
            sy    = sy - dy;
            resid = resid + longint'(ATAN_TURNS[i]);
         end
      end
      case (quad)
         QUAD_0: begin c = cx;  s = sy;  end
         QUAD_1: begin c = -sy; s = cx;  end
         QUAD_2: begin c = -cx; s = -sy; end
         default: begin c = sy; s = -cx; end
      endcase
      v.x  = clamp16((longint'(px) * c + longint'(py) * s + (64'sd1 <<< 29)) >>> 30);
      v.y  = clamp16((longint'(py) * c - longint'(px) * s + (64'sd1 <<< 29)) >>> 30);
      v.z  = pz;
      v.nx = nx;
      v.ny = ny;
      v.nz = nz;
      return v;
   endfunction

   always @(posedge clock) begin
      deformed_vertex_type want;
      if (reset) begin
         rate_shadow = '0;
         bad_beats   = 0;
         twisted_vertices.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (twisted_vertices.size() == 0) begin
               if (bad_beats < 10)
                  $display("%0t: rsp beat with nothing expected: x=%0d y=%0d z=%0d",
                           $realtime, rsp_out_x, rsp_out_y, rsp_out_z);
               bad_beats++;
            end else begin
               want = twisted_vertices.pop_front();
               if (rsp_out_x !== want.x || rsp_out_y !== want.y ||
                   rsp_out_z !== want.z || rsp_out_norm_x !== want.nx ||
                   rsp_out_norm_y !== want.ny || rsp_out_norm_z !== want.nz) begin
                  if (bad_beats < 10)
                     $display({"%0t: rsp mismatch exp x=%0d y=%0d z=%0d n=%0d/%0d/%0d",
                               " got x=%0d y=%0d z=%0d n=%0d/%0d/%0d"}, $realtime,
                              want.x, want.y, want.z, want.nx, want.ny, want.nz,
                              rsp_out_x, rsp_out_y, rsp_out_z,
                              rsp_out_norm_x, rsp_out_norm_y, rsp_out_norm_z);
                  bad_beats++;
               end
            end
         end
         if (req_valid && !req_stall)
            twisted_vertices.insert(twisted_vertices.size(),
                                    twist_vertex(req_pos_x, req_pos_y, req_pos_z,
                                                 req_norm_x, req_norm_y, req_norm_z,
                                                 rate_shadow));
         if (csr_wr_en)
            rate_shadow = csr_wr_data;
      end
      mismatch_count <= bad_beats;
      pending_count  <= twisted_vertices.size();
   end

endmodule

@@ verif/vertex_twist_deform_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vertex_twist_deform_unit_tb
// Stimulus and verdict for the vertex twist deformer. A directed sweep covers
// field extremes, quadrant boundaries, wrapping angles and saturation. Random
// vertices then run under a series of twist rates that includes both ends of
// the register. Both sides idle at random, and the receiver holds off for
// one long stretch. Checking is done in vertex_twist_deform_checker.
// ----------------------------------------------------------------------------
module vertex_twist_deform_unit_tb;
   import vtd_pkg::*;

   localparam int PIPE_DEPTH     = CORDIC_STAGES + 5;
   localparam int HOLD_CYCLES    = 150;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 40;

   logic      clock;
   logic      reset;
   logic      csr_wr_en;
   coord_type csr_wr_data;
   logic      req_valid;
   logic      req_stall;
   coord_type req_pos_x, req_pos_y, req_pos_z;
   coord_type req_norm_x, req_norm_y, req_norm_z;
   logic      rsp_valid;
   logic      rsp_stall;
   coord_type rsp_out_x, rsp_out_y, rsp_out_z;
   coord_type rsp_out_norm_x, rsp_out_norm_y, rsp_out_norm_z;

   int        mismatch_count;
   int        pending_count;
   int        vertices_sent;
   int        rates_written;
   int        hold_requests;
   int        holds_done;
   int        idle_cycles;
   bit        sender_steady;
   bit        receiver_steady;

   vertex_twist_deform_unit dut (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_pos_z      (req_pos_z),
      .req_norm_x     (req_norm_x),
      .req_norm_y     (req_norm_y),
      .req_norm_z     (req_norm_z),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_out_z      (rsp_out_z),
      .rsp_out_norm_x (rsp_out_norm_x),
      .rsp_out_norm_y (rsp_out_norm_y),
      .rsp_out_norm_z (rsp_out_norm_z)
   );

   vertex_twist_deform_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_pos_z      (req_pos_z),
      .req_norm_x     (req_norm_x),
      .req_norm_y     (req_norm_y),
      .req_norm_z     (req_norm_z),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_out_z      (rsp_out_z),
      .rsp_out_norm_x (rsp_out_norm_x),
      .rsp_out_norm_y (rsp_out_norm_y),
      .rsp_out_norm_z (rsp_out_norm_z),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly short, now and then long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic coord_type pick_coord();
      case ($urandom_range(0, 9))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return coord_type'(int'($urandom_range(0, 64)) - 32);
         default: return coord_type'($urandom);
      endcase
   endfunction

   task automatic send_vertex(input coord_type px, input coord_type py, input coord_type pz,
                              input coord_type nx, input coord_type ny, input coord_type nz);
      int gap;
      gap = 0;
      if (!sender_steady && $urandom_range(0, 3) == 0)
         gap = idle_len();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_pos_x  = px;
      req_pos_y  = py;
      req_pos_z  = pz;
      req_norm_x = nx;
      req_norm_y = ny;
      req_norm_z = nz;
      req_valid  = 1'b1;
      do @(posedge clock); while (req_stall);
      vertices_sent++;
      @(negedge clock);
   endtask

   task automatic send_random_vertex();
      send_vertex(pick_coord(), pick_coord(), pick_coord(),
                  pick_coord(), pick_coord(), pick_coord());
   endtask

   task automatic drain_pipe();
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (PIPE_DEPTH) @(negedge clock);
   endtask

   task automatic write_rate(input coord_type rate);
      csr_wr_en   = 1'b1;
      csr_wr_data = rate;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      rates_written++;
   endtask

   // angles of 1 rad/unit: pi/4, quadrant edges, a full turn, both z extremes
   task automatic directed_sweep();
      coord_type zs[10];
      zs = '{16'sd3217, 16'sd6434, 16'sd12868, 16'sd19302, 16'sd25736,
             -16'sd6434, -16'sd12868, 16'sh7FFF, 16'sh8000, 16'sd0};
      send_vertex(16'sh7FFF, 16'sh7FFF, 16'sd3217, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
      send_vertex(16'sh8000, 16'sh8000, 16'sd3217, 16'sh8000, 16'sh7FFF, 16'sh8000);
      send_vertex(16'sh7FFF, 16'sh8000, -16'sd3217, 16'sd0, 16'sd0, 16'sd0);
      send_vertex(16'sh8000, 16'sh7FFF, 16'sd12868, 16'shFFFF, 16'sd1, 16'shFFFF);
      foreach (zs[i])
         send_vertex(16'sd4096, -16'sd2048, zs[i], 16'sd0, 16'sh7FFF, 16'sd0);
   endtask

   initial begin
      int hold;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_done) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            holds_done++;
         end else if (hold > 0) begin
            rsp_stall = 1'b1;
            hold--;
         end else if (receiver_steady || $urandom_range(0, 5) != 0) begin
            rsp_stall = 1'b0;
         end else begin
            hold      = idle_len() - 1;
            rsp_stall = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat moved for %0d cycles, %0d still expected",
                  idle_cycles, pending_count);
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      coord_type rate_plan[10];
      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      req_valid       = 1'b0;
      rsp_stall       = 1'b0;
      req_pos_x       = '0;
      req_pos_y       = '0;
      req_pos_z       = '0;
      req_norm_x      = '0;
      req_norm_y      = '0;
      req_norm_z      = '0;
      vertices_sent   = 0;
      rates_written   = 0;
      hold_requests   = 0;
      holds_done      = 0;
      idle_cycles     = 0;
      sender_steady   = 1'b1;
      receiver_steady = 1'b1;
      rate_plan = '{16'sd16384, -16'sd16384, 16'sh7FFF, 16'sh8000, 16'sd1, -16'sd1,
                    16'sd0, 16'sd0, 16'sd0, 16'sd0};
      for (int i = 6; i < 10; i++)
         rate_plan[i] = coord_type'(int'($urandom_range(0, 32768)) - 16384);
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // rate still at its reset value
      send_vertex(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
      send_vertex(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000);
      send_vertex(16'sd1, -16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      drain_pipe();
      write_rate(16'sd16384);
      directed_sweep();
      drain_pipe();

      foreach (rate_plan[p]) begin
         write_rate(rate_plan[p]);
         sender_steady   = (p == 0 || p == 2);
         receiver_steady = (p == 0);
         if (p == 2)
            hold_requests++;
         repeat (PHASE_ITEMS) send_random_vertex();
         drain_pipe();
      end

      $display("Sent %0d vertices under %0d twist rate settings, full-scale and wrapping",
               vertices_sent, rates_written);
      $display("angles included, with saturation, idle gaps and one long rsp hold-off.");
      if (mismatch_count == 0 && pending_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

@@ vertex_twist_deform_unit.f @@
sv/vtd_pkg.sv
sv/vtd_front.sv
sv/vtd_cell.sv
sv/vtd_back.sv
sv/vertex_twist_deform_unit.sv
verif/vertex_twist_deform_checker.sv
verif/vertex_twist_deform_unit_tb.sv
